FILE: design/lorenz_euler_integrator_defines.svh
// Assertion macros shared by the integrator RTL.
// Every macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef LORENZ_EULER_INTEGRATOR_DEFINES_SVH
`define LORENZ_EULER_INTEGRATOR_DEFINES_SVH

// Same-cycle implication.
`define LEI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LEI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lei_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lei_pkg;

    localparam int FIELD_W     = 40;
    localparam int COEF_W      = 35;
    localparam int STEP_W      = 25;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 35;
    localparam int MUL_DIGIT_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RHO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BETA  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd4;

    localparam logic [COEF_W-1:0]  SIGMA_RESET = 35'd167772160;
    localparam logic [COEF_W-1:0]  RHO_RESET   = 35'd469762048;
    localparam logic [COEF_W-1:0]  BETA_RESET  = 35'd44739243;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 25'd167772;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd10;

    typedef struct packed {
        logic                      restart;
        logic signed [FIELD_W-1:0] start_x;
        logic signed [FIELD_W-1:0] start_y;
        logic signed [FIELD_W-1:0] start_z;
    } in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] sample_x;
        logic signed [FIELD_W-1:0] sample_y;
        logic signed [FIELD_W-1:0] sample_z;
        logic                      saturated;
    } out_t;

    typedef struct packed {
        logic [COEF_W-1:0]  sigma_coef;
        logic [COEF_W-1:0]  rho_coef;
        logic [COEF_W-1:0]  beta_coef;
        logic [STEP_W-1:0]  step_size;
        logic [COUNT_W-1:0] steps_per_sample;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic sat;
    } mul_status_t;

endpackage

`default_nettype wire

FILE: design/lei_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module lei_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lei_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lei_pkg::CFG_DATA_W-1:0]     cfg_data,
    output lei_pkg::cfg_t                           cfg
);

    lei_pkg::cfg_t cfg_reg;
    lei_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                lei_pkg::REG_SIGMA: cfg_next.sigma_coef = cfg_data[lei_pkg::COEF_W-1:0];
                lei_pkg::REG_RHO:   cfg_next.rho_coef   = cfg_data[lei_pkg::COEF_W-1:0];
                lei_pkg::REG_BETA:  cfg_next.beta_coef  = cfg_data[lei_pkg::COEF_W-1:0];
                lei_pkg::REG_STEP:  cfg_next.step_size  = cfg_data[lei_pkg::STEP_W-1:0];
                lei_pkg::REG_COUNT:
                begin
                    cfg_next.steps_per_sample = cfg_data[lei_pkg::COUNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sigma_coef       <= lei_pkg::SIGMA_RESET;
            cfg_reg.rho_coef         <= lei_pkg::RHO_RESET;
            cfg_reg.beta_coef        <= lei_pkg::BETA_RESET;
            cfg_reg.step_size        <= lei_pkg::STEP_RESET;
            cfg_reg.steps_per_sample <= lei_pkg::COUNT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/lei_mul.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lorenz_euler_integrator_defines.svh"

// Signed fixed-point multiply: magnitude times one 16-bit digit per cycle,
// then round half away from zero, then clamp to the VW-bit range.
module lei_mul #(
    parameter int OPW = 40,
    parameter int VW  = 40,
    parameter int FB  = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic signed [OPW-1:0]  a,
    input  wire logic signed [OPW-1:0]  b,
    output logic signed [VW-1:0]        result,
    output lei_pkg::mul_status_t        stat
);

    localparam int DW = lei_pkg::MUL_DIGIT_W;
    localparam int ND = (OPW + DW - 1) / DW;
    localparam int BW = ND * DW;
    localparam int AW = OPW + BW;
    localparam int RW = AW + 1;
    localparam int QW = RW - FB;
    localparam int CW = (ND > 1) ? $clog2(ND) : 1;

    localparam logic [QW-1:0] LIM_NEG = QW'(1) << (VW - 1);
    localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);
    localparam logic [RW-1:0] HALF    = RW'(1) << (FB - 1);

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_RND, M_FIN} state_t;

    state_t                  state_reg, state_next;
    logic [OPW-1:0]          mag_a_reg, mag_a_next;
    logic [BW-1:0]           b_sh_reg, b_sh_next;
    logic                    neg_reg, neg_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [AW-1:0]           acc_reg, acc_next;
    logic [RW-1:0]           rnd_reg, rnd_next;
    logic signed [VW-1:0]    result_reg, result_next;
    logic                    done_reg, done_next;
    logic                    sat_reg, sat_next;

    logic [OPW-1:0]          mag_a_in;
    logic [OPW-1:0]          mag_b_in;
    logic [OPW+DW-1:0]       pp;
    logic [QW-1:0]           q;
    logic [QW-1:0]           lim;
    logic                    over;
    logic [QW-1:0]           qc;
    logic [VW-1:0]           qv;

    assign mag_a_in = a[OPW-1] ? OPW'(-a) : OPW'(a);
    assign mag_b_in = b[OPW-1] ? OPW'(-b) : OPW'(b);
    assign pp       = mag_a_reg * b_sh_reg[BW-1 -: DW];
    assign q        = rnd_reg[RW-1:FB];
    assign lim      = neg_reg ? LIM_NEG : LIM_POS;
    assign over     = q > lim;
    assign qc       = over ? lim : q;
    assign qv       = qc[VW-1:0];

    assign result    = result_reg;
    assign stat.busy = state_reg != M_IDLE;
    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;

    always_comb
    begin
        state_next  = state_reg;
        mag_a_next  = mag_a_reg;
        b_sh_next   = b_sh_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        rnd_next    = rnd_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        sat_next    = sat_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    mag_a_next = mag_a_in;
                    b_sh_next  = BW'(mag_b_in);
                    neg_next   = a[OPW-1] ^ b[OPW-1];
                    cnt_next   = CW'(ND - 1);
                    acc_next   = '0;
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                // most significant digit first
                acc_next  = {acc_reg[AW-DW-1:0], {DW{1'b0}}} + AW'(pp);
                b_sh_next = {b_sh_reg[BW-DW-1:0], {DW{1'b0}}};
                if (cnt_reg == '0)
                begin
                    state_next = M_RND;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            M_RND:
            begin
                rnd_next   = RW'(acc_reg) + HALF;
                state_next = M_FIN;
            end
            M_FIN:
            begin
                result_next = neg_reg ? -qv : qv;
                sat_next    = over;
                done_next   = 1'b1;
                state_next  = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= M_IDLE;
            mag_a_reg  <= '0;
            b_sh_reg   <= '0;
            neg_reg    <= 1'b0;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            rnd_reg    <= '0;
            result_reg <= '0;
            done_reg   <= 1'b0;
            sat_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mag_a_reg  <= mag_a_next;
            b_sh_reg   <= b_sh_next;
            neg_reg    <= neg_next;
            cnt_reg    <= cnt_next;
            acc_reg    <= acc_next;
            rnd_reg    <= rnd_next;
            result_reg <= result_next;
            done_reg   <= done_next;
            sat_reg    <= sat_next;
        end
    end

    `LEI_ASSERT_IMPL(a_mul_start_idle, start, (state_reg == M_IDLE), "multiply started while busy")
    `LEI_ASSERT_NEXT(a_mul_fin_done, (state_reg == M_FIN), done_reg, "finish without done")
    `LEI_ASSERT_NEXT(a_mul_done_pulse, done_reg, (!done_reg), "done longer than one cycle")

endmodule

`default_nettype wire

FILE: design/lorenz_euler_integrator.sv
// Each item runs N Euler steps between item accept and result valid,
// N = min(steps_per_sample, MAX_STEPS).
// Each Euler step: 7 digit-serial multiplies, plus 7 add/sub operations.
// Items are taken one at a time: a new one is accepted only after the previous result is
// registered, which waits while an older result still waits on out_ready.
// Reset: async active low; state returns to the origin, registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "lorenz_euler_integrator_defines.svh"

module lorenz_euler_integrator #(
    parameter int              VALUE_WIDTH   = 40,
    parameter int              FRACTION_BITS = 24,
    parameter longint unsigned MAX_STEPS     = 65535
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lei_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lei_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire lei_pkg::in_t                       in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output lei_pkg::out_t                           out_data
);

    localparam int VW  = VALUE_WIDTH;
    localparam int FW  = lei_pkg::FIELD_W;
    localparam int CNW = lei_pkg::COUNT_W;
    localparam int OPW = (VW > lei_pkg::COEF_W) ? VW : lei_pkg::COEF_W;
    localparam int SW  = OPW + 1;
    localparam int EW  = (VW > FW) ? VW : FW;

    localparam logic signed [SW-1:0] ALU_HI = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [SW-1:0] ALU_LO = ~ALU_HI;
    localparam logic signed [EW-1:0] LD_HI  = {{(EW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [EW-1:0] LD_LO  = ~LD_HI;
    localparam logic signed [EW-1:0] OUT_HI = {{(EW-FW+1){1'b0}}, {(FW-1){1'b1}}};
    localparam logic signed [EW-1:0] OUT_LO = ~OUT_HI;
    localparam logic [32:0]          MAX_W  = 33'(MAX_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_D, ST_MUL_DX, ST_T, ST_MUL_XT, ST_DY, ST_MUL_XY, ST_MUL_BZ,
        ST_DZ, ST_MUL_UX, ST_ADD_X, ST_MUL_UY, ST_ADD_Y, ST_MUL_UZ, ST_ADD_Z, ST_OUT
    } state_t;

    // {saturated, value} from the load clamp
    function automatic logic [VW:0] clamp_load(input logic signed [FW-1:0] v);
        logic signed [EW-1:0] e;
        logic [VW:0]          r;
        e = EW'(v);
        if (e > LD_HI)
            r = {1'b1, LD_HI[VW-1:0]};
        else if (e < LD_LO)
            r = {1'b1, LD_LO[VW-1:0]};
        else
            r = {1'b0, e[VW-1:0]};
        return r;
    endfunction

    function automatic logic [FW:0] clamp_out(input logic signed [VW-1:0] v);
        logic signed [EW-1:0] e;
        logic [FW:0]          r;
        e = EW'(v);
        if (e > OUT_HI)
            r = {1'b1, OUT_HI[FW-1:0]};
        else if (e < OUT_LO)
            r = {1'b1, OUT_LO[FW-1:0]};
        else
            r = {1'b0, e[FW-1:0]};
        return r;
    endfunction

    lei_pkg::cfg_t        cfg;
    lei_pkg::mul_status_t mul_stat;
    logic signed [VW-1:0] mul_res;

    state_t               state_reg, state_next;
    logic signed [VW-1:0] x_reg, x_next;
    logic signed [VW-1:0] y_reg, y_next;
    logic signed [VW-1:0] z_reg, z_next;
    logic signed [VW-1:0] tmp_reg, tmp_next;
    logic signed [VW-1:0] dx_reg, dx_next;
    logic signed [VW-1:0] dy_reg, dy_next;
    logic signed [VW-1:0] dz_reg, dz_next;
    logic [CNW-1:0]       steps_reg, steps_next;
    logic                 sat_reg, sat_next;
    logic                 mul_start_reg, mul_start_next;
    logic                 out_valid_reg, out_valid_next;
    lei_pkg::out_t        out_data_reg, out_data_next;

    logic signed [OPW-1:0] alu_a, alu_b;
    logic                  alu_sub, alu_en;
    logic signed [SW-1:0]  alu_sum;
    logic                  alu_sat;
    logic signed [VW-1:0]  alu_res;
    logic signed [OPW-1:0] mul_a, mul_b;

    logic [VW:0]           ld_x, ld_y, ld_z;
    logic [FW:0]           oc_x, oc_y, oc_z;
    logic [CNW-1:0]        steps_n;
    logic                  mul_wait;

    lei_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lei_mul #(
        .OPW (OPW),
        .VW  (VW),
        .FB  (FRACTION_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start_reg),
        .a      (mul_a),
        .b      (mul_b),
        .result (mul_res),
        .stat   (mul_stat)
    );

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign mul_wait = state_reg inside {ST_MUL_DX, ST_MUL_XT, ST_MUL_XY, ST_MUL_BZ,
                                        ST_MUL_UX, ST_MUL_UY, ST_MUL_UZ};

    assign ld_x = clamp_load(in_data.start_x);
    assign ld_y = clamp_load(in_data.start_y);
    assign ld_z = clamp_load(in_data.start_z);
    assign oc_x = clamp_out(x_reg);
    assign oc_y = clamp_out(y_reg);
    assign oc_z = clamp_out(z_reg);

    assign steps_n = (33'(cfg.steps_per_sample) > MAX_W) ? MAX_W[CNW-1:0]
                                                          : cfg.steps_per_sample;

    // shared saturating add/sub
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        alu_en  = 1'b1;
        case (state_reg)
            ST_D:
            begin
                alu_a = OPW'(y_reg);
                alu_b = OPW'(x_reg);
            end
            ST_T:
            begin
                alu_a = OPW'(signed'(cfg.rho_coef));
                alu_b = OPW'(z_reg);
            end
            ST_DY:
            begin
                alu_a = OPW'(tmp_reg);
                alu_b = OPW'(y_reg);
            end
            ST_DZ:
            begin
                alu_a = OPW'(tmp_reg);
                alu_b = OPW'(dz_reg);
            end
            ST_ADD_X:
            begin
                alu_a   = OPW'(x_reg);
                alu_b   = OPW'(tmp_reg);
                alu_sub = 1'b0;
            end
            ST_ADD_Y:
            begin
                alu_a   = OPW'(y_reg);
                alu_b   = OPW'(tmp_reg);
                alu_sub = 1'b0;
            end
            ST_ADD_Z:
            begin
                alu_a   = OPW'(z_reg);
                alu_b   = OPW'(tmp_reg);
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_en = 1'b0;
            end
        endcase
        alu_sum = alu_sub ? SW'(alu_a) - SW'(alu_b) : SW'(alu_a) + SW'(alu_b);
        alu_sat = (alu_sum > ALU_HI) || (alu_sum < ALU_LO);
        if (alu_sum > ALU_HI)
            alu_res = ALU_HI[VW-1:0];
        else if (alu_sum < ALU_LO)
            alu_res = ALU_LO[VW-1:0];
        else
            alu_res = alu_sum[VW-1:0];
    end

    // multiplier operands, held for the whole multiply state
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_DX:
            begin
                mul_a = OPW'(signed'(cfg.sigma_coef));
                mul_b = OPW'(tmp_reg);
            end
            ST_MUL_XT:
            begin
                mul_a = OPW'(x_reg);
                mul_b = OPW'(tmp_reg);
            end
            ST_MUL_XY:
            begin
                mul_a = OPW'(x_reg);
                mul_b = OPW'(y_reg);
            end
            ST_MUL_BZ:
            begin
                mul_a = OPW'(signed'(cfg.beta_coef));
                mul_b = OPW'(z_reg);
            end
            ST_MUL_UX:
            begin
                mul_a = OPW'(cfg.step_size);
                mul_b = OPW'(dx_reg);
            end
            ST_MUL_UY:
            begin
                mul_a = OPW'(cfg.step_size);
                mul_b = OPW'(dy_reg);
            end
            ST_MUL_UZ:
            begin
                mul_a = OPW'(cfg.step_size);
                mul_b = OPW'(dz_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        tmp_next       = tmp_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        steps_next     = steps_reg;
        sat_next       = sat_reg;
        mul_start_next = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (alu_en && alu_sat)
            sat_next = 1'b1;
        if (mul_stat.done && mul_stat.sat)
            sat_next = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sat_next = 1'b0;
                    if (in_data.restart)
                    begin
                        x_next   = ld_x[VW-1:0];
                        y_next   = ld_y[VW-1:0];
                        z_next   = ld_z[VW-1:0];
                        sat_next = ld_x[VW] | ld_y[VW] | ld_z[VW];
                    end
                    steps_next = steps_n;
                    state_next = (steps_n == '0) ? ST_OUT : ST_D;
                end
            end
            ST_D:
            begin
                tmp_next       = alu_res;
                mul_start_next = 1'b1;
                state_next     = ST_MUL_DX;
            end
            ST_MUL_DX:
            begin
                if (mul_stat.done)
                begin
                    dx_next    = mul_res;
                    state_next = ST_T;
                end
            end
            ST_T:
            begin
                tmp_next       = alu_res;
                mul_start_next = 1'b1;
                state_next     = ST_MUL_XT;
            end
            ST_MUL_XT:
            begin
                if (mul_stat.done)
                begin
                    tmp_next   = mul_res;
                    state_next = ST_DY;
                end
            end
            ST_DY:
            begin
                dy_next        = alu_res;
                mul_start_next = 1'b1;
                state_next     = ST_MUL_XY;
            end
            ST_MUL_XY:
            begin
                if (mul_stat.done)
                begin
                    tmp_next       = mul_res;
                    mul_start_next = 1'b1;
                    state_next     = ST_MUL_BZ;
                end
            end
            ST_MUL_BZ:
            begin
                // beta*z parks in dz until the subtract
                if (mul_stat.done)
                begin
                    dz_next    = mul_res;
                    state_next = ST_DZ;
                end
            end
            ST_DZ:
            begin
                dz_next        = alu_res;
                mul_start_next = 1'b1;
                state_next     = ST_MUL_UX;
            end
            ST_MUL_UX:
            begin
                if (mul_stat.done)
                begin
                    tmp_next   = mul_res;
                    state_next = ST_ADD_X;
                end
            end
            ST_ADD_X:
            begin
                x_next         = alu_res;
                mul_start_next = 1'b1;
                state_next     = ST_MUL_UY;
            end
            ST_MUL_UY:
            begin
                if (mul_stat.done)
                begin
                    tmp_next   = mul_res;
                    state_next = ST_ADD_Y;
                end
            end
            ST_ADD_Y:
            begin
                y_next         = alu_res;
                mul_start_next = 1'b1;
                state_next     = ST_MUL_UZ;
            end
            ST_MUL_UZ:
            begin
                if (mul_stat.done)
                begin
                    tmp_next   = mul_res;
                    state_next = ST_ADD_Z;
                end
            end
            ST_ADD_Z:
            begin
                z_next     = alu_res;
                steps_next = steps_reg - CNW'(1);
                state_next = (steps_reg == CNW'(1)) ? ST_OUT : ST_D;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.sample_x  = oc_x[FW-1:0];
                    out_data_next.sample_y  = oc_y[FW-1:0];
                    out_data_next.sample_z  = oc_z[FW-1:0];
                    out_data_next.saturated = sat_reg | oc_x[FW] | oc_y[FW] | oc_z[FW];
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            tmp_reg       <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            dz_reg        <= '0;
            steps_reg     <= '0;
            sat_reg       <= 1'b0;
            mul_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            z_reg         <= z_next;
            tmp_reg       <= tmp_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            dz_reg        <= dz_next;
            steps_reg     <= steps_next;
            sat_reg       <= sat_next;
            mul_start_reg <= mul_start_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    `LEI_ASSERT_IMPL(a_start_when_free, mul_start_reg, (!mul_stat.busy), "multiplier busy at start")
    `LEI_ASSERT_IMPL(a_done_in_wait, mul_stat.done, mul_wait, "multiply result outside a wait state")
    `LEI_ASSERT_IMPL(a_steps_left, (state_reg == ST_D), (steps_reg != '0), "step with no steps left")

endmodule

`default_nettype wire
